### sv/sbl_pkg.sv
// shared types and constants of the sorted byte list unit
package sbl_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned CmdW         = 2;
  localparam int unsigned ValueW       = 8;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned CountW       = 5;

  // command codes
  localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
  localparam logic [CmdW-1:0] CMD_DELETE = 2'd1;
  localparam logic [CmdW-1:0] CMD_SEARCH = 2'd2;

  // status codes
  localparam logic [StatusW-1:0] ST_DONE      = 2'd0;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY     = 2'd2;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic [ValueW-1:0] item_value;
  } item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  entry_count;
  } result_t;

endpackage

### sv/sorted_byte_list_unit.sv
// sorted byte list: ordered store with insert, delete and search commands
//
// usage
//   command beat: item_i is taken at a rising edge with start high and busy low.
//   save for immediate results, busy is high from that edge to the result beat.
//   result beat: done_o is high for exactly one cycle with result_o valid; the
//   receiver has no way to hold it off, so it must take every result beat.
//   every command gives exactly one result beat carrying status and the count
//   of entries held after the command.
// command flow
//   unused command, insert into a full store, delete or search on an empty one:
//   result beat in the cycle after the command beat, busy never rises.
//   otherwise the entries sit in one memory with one read port and a registered
//   read; each entry examined takes a read state and a compare state, and each
//   moved entry a read and then a write back one place over.
//   the longest command is an insert at the front of a list one short of
//   full; busy drops in the cycle that shows the result beat, so the next
//   command may follow then.
// reset: clears the entry count and the controller; the memory is not cleared
module sorted_byte_list_unit #(
  parameter int unsigned DEPTH = sbl_pkg::DefaultDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  sbl_pkg::item_t    item_i,
  output logic              done_o,
  output sbl_pkg::result_t  result_o
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    StIdle,
    StScanRd,
    StScanCmp,
    StShiftRd,
    StShiftWr,
    StPut
  } state_e;

  state_e state_q;

  // latched command beat
  logic [sbl_pkg::CmdW-1:0]   cmd_q;
  logic [sbl_pkg::ValueW-1:0] val_q;

  logic [CntW-1:0] count_q;   // entries held
  logic [CntW-1:0] idx_q;     // scan position
  logic [CntW-1:0] pos_q;     // insert or delete position
  logic [CntW-1:0] j_q;       // shift write position

  logic                         done_q;
  logic [sbl_pkg::StatusW-1:0]  status_q;

  // entry memory
  logic [sbl_pkg::ValueW-1:0] mem [DEPTH];
  logic [sbl_pkg::ValueW-1:0] rdata_q;

  logic                       mem_re;
  logic [IdxW-1:0]            mem_raddr;
  logic                       mem_we;
  logic [IdxW-1:0]            mem_waddr;
  logic [sbl_pkg::ValueW-1:0] mem_wdata;

  logic [CntW-1:0] j_dec;
  logic [CntW-1:0] j_inc;
  logic            is_insert;

  assign j_dec     = j_q - CntW'(1);
  assign j_inc     = j_q + CntW'(1);
  assign is_insert = (cmd_q == sbl_pkg::CMD_INSERT);

  // memory port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = idx_q[IdxW-1:0];
    mem_we    = 1'b0;
    mem_waddr = j_q[IdxW-1:0];
    mem_wdata = rdata_q;
    case (state_q)
      StScanRd: begin
        mem_re    = (idx_q != count_q);
        mem_raddr = idx_q[IdxW-1:0];
      end
      StShiftRd: begin
        if (is_insert) begin
          // open a gap: move entry j-1 up to j
          mem_re    = (j_q != pos_q);
          mem_raddr = j_dec[IdxW-1:0];
        end else begin
          // close the gap: move entry j+1 down to j
          mem_re    = (j_inc < count_q);
          mem_raddr = j_inc[IdxW-1:0];
        end
      end
      StShiftWr: begin
        mem_we    = 1'b1;
        mem_waddr = j_q[IdxW-1:0];
        mem_wdata = rdata_q;
      end
      StPut: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q[IdxW-1:0];
        mem_wdata = val_q;
      end
      default: begin
        mem_re = 1'b0;
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // controller and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= sbl_pkg::ST_DONE;
      cmd_q    <= sbl_pkg::CMD_INSERT;
      val_q    <= '0;
      idx_q    <= '0;
      pos_q    <= '0;
      j_q      <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (start) begin
            cmd_q <= item_i.command;
            val_q <= item_i.item_value;
            idx_q <= '0;
            case (item_i.command)
              sbl_pkg::CMD_INSERT: begin
                if (count_q == CntW'(DEPTH)) begin
                  done_q   <= 1'b1;
                  status_q <= sbl_pkg::ST_FULL;
                end else begin
                  state_q <= StScanRd;
                end
              end
              sbl_pkg::CMD_DELETE, sbl_pkg::CMD_SEARCH: begin
                if (count_q == '0) begin
                  done_q   <= 1'b1;
                  status_q <= sbl_pkg::ST_EMPTY;
                end else begin
                  state_q <= StScanRd;
                end
              end
              default: begin
                // unused code: ignored, reported as not found
                done_q   <= 1'b1;
                status_q <= sbl_pkg::ST_NOT_FOUND;
              end
            endcase
          end
        end
        StScanRd: begin
          if (idx_q == count_q) begin
            // ran off the end of the list
            if (is_insert) begin
              pos_q   <= count_q;
              j_q     <= count_q;
              state_q <= StShiftRd;
            end else begin
              done_q   <= 1'b1;
              status_q <= sbl_pkg::ST_NOT_FOUND;
              state_q  <= StIdle;
            end
          end else begin
            state_q <= StScanCmp;
          end
        end
        StScanCmp: begin
          if (is_insert) begin
            if (rdata_q >= val_q) begin
              pos_q   <= idx_q;
              j_q     <= count_q;
              state_q <= StShiftRd;
            end else begin
              idx_q   <= idx_q + CntW'(1);
              state_q <= StScanRd;
            end
          end else if (rdata_q == val_q) begin
            if (cmd_q == sbl_pkg::CMD_SEARCH) begin
              done_q   <= 1'b1;
              status_q <= sbl_pkg::ST_DONE;
              state_q  <= StIdle;
            end else begin
              pos_q   <= idx_q;
              j_q     <= idx_q;
              state_q <= StShiftRd;
            end
          end else if (rdata_q > val_q) begin
            // list is ascending, no match further on
            done_q   <= 1'b1;
            status_q <= sbl_pkg::ST_NOT_FOUND;
            state_q  <= StIdle;
          end else begin
            idx_q   <= idx_q + CntW'(1);
            state_q <= StScanRd;
          end
        end
        StShiftRd: begin
          if (is_insert) begin
            state_q <= (j_q == pos_q) ? StPut : StShiftWr;
          end else if (j_inc < count_q) begin
            state_q <= StShiftWr;
          end else begin
            count_q  <= count_q - CntW'(1);
            done_q   <= 1'b1;
            status_q <= sbl_pkg::ST_DONE;
            state_q  <= StIdle;
          end
        end
        StShiftWr: begin
          j_q     <= is_insert ? j_dec : j_inc;
          state_q <= StShiftRd;
        end
        StPut: begin
          count_q  <= count_q + CntW'(1);
          done_q   <= 1'b1;
          status_q <= sbl_pkg::ST_DONE;
          state_q  <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy                 = (state_q != StIdle);
  assign done_o               = done_q;
  assign result_o.status      = status_q;
  assign result_o.entry_count = sbl_pkg::CountW'(count_q);

endmodule
